>>> src/gtpv2_pkg.sv
// Shared types, constants and header checks for the GTPv2-C field extractor.
// No dependencies; used by the top level.
package gtpv2_pkg;

    localparam int NEST_DEPTH_DEF      = 2;
    localparam int IMSI_MAX_DIGITS_DEF = 15;

    localparam logic [15:0] MIN_PKT_LEN   = 16'd8;
    localparam logic [4:0]  HDR_LEN_SHORT = 5'd8;
    localparam logic [4:0]  HDR_LEN_LONG  = 5'd12;
    localparam logic [2:0]  GTP_VERSION   = 3'd2;
    localparam int          T_FLAG_BIT    = 3;

    localparam logic [7:0] MSG_FIRST_LO = 8'd32;
    localparam logic [7:0] MSG_FIRST_HI = 8'd37;
    localparam logic [7:0] MSG_EXTRA_A  = 8'd170;
    localparam logic [7:0] MSG_EXTRA_B  = 8'd171;

    localparam logic [7:0] IE_IMSI       = 8'd1;
    localparam logic [7:0] IE_CAUSE      = 8'd2;
    localparam logic [7:0] IE_EBI        = 8'd73;
    localparam logic [7:0] IE_PAA        = 8'd79;
    localparam logic [7:0] IE_FTEID      = 8'd87;
    localparam logic [7:0] IE_BEARER_CTX = 8'd93;

    localparam logic [7:0]  PAA_TYPE_IPV4 = 8'd1;
    localparam logic [15:0] IE_HDR_BYTES  = 16'd4;
    localparam logic [15:0] SHIFT_BYTES   = 16'd5;
    localparam logic [15:0] LAST_ADDR_IDX = 16'd4;
    localparam logic [3:0]  BCD_MAX       = 4'd9;
    localparam logic [3:0]  BCD_FILLER    = 4'hf;
    localparam logic [3:0]  IMSI_SLOTS    = 4'd15;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_IEH,
        PH_VAL,
        PH_DONE
    } t_phase;

    function automatic logic [4:0] hdr_len(input logic [7:0] flags);
        hdr_len = flags[T_FLAG_BIT] ? HDR_LEN_LONG : HDR_LEN_SHORT;
    endfunction

    function automatic logic header_ok(input logic [7:0] flags, input logic [7:0] mtype,
                                       input logic [15:0] tlen);
        logic type_ok;
        type_ok = (mtype inside {[MSG_FIRST_LO:MSG_FIRST_HI], MSG_EXTRA_A, MSG_EXTRA_B});
        header_ok = (tlen >= MIN_PKT_LEN) && (flags[7:5] == GTP_VERSION) && type_ok &&
                    (tlen >= 16'(hdr_len(flags)));
    endfunction

endpackage

>>> src/gtpv2c_field_extract.sv
// Top level of the GTPv2-C field extractor: header check, IE walk and captures.
// Depends on gtpv2_pkg for constants, the phase type and the header checks.
// A last byte passes the input register, then its result is registered for output.
// Throughput: one byte per cycle; the input stalls only while a last byte waits in
// the input register behind a held result.
// Reset (synchronous, active low) empties both registers and clears the parse state.
module gtpv2c_field_extract #(
    parameter int NEST_DEPTH      = gtpv2_pkg::NEST_DEPTH_DEF,
    parameter int IMSI_MAX_DIGITS = gtpv2_pkg::IMSI_MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_total_len,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic [7:0]  o_msg_type,
    output logic [31:0] o_teid,
    output logic        o_has_teid,
    output logic [7:0]  o_cause_code,
    output logic        o_has_cause,
    output logic [3:0]  o_bearer_id,
    output logic        o_has_bearer_id,
    output logic [31:0] o_ue_ipv4,
    output logic        o_has_ue_ip,
    output logic [59:0] o_imsi_bcd,
    output logic [3:0]  o_imsi_count
);

    localparam int LEVELS = NEST_DEPTH + 1;
    localparam int NW     = $clog2(LEVELS);

    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_first;
    logic        r_in_last;
    logic [15:0] r_in_tlen;
    logic        proc_fire;

    logic [15:0]            r_bpos, n_bpos;
    gtpv2_pkg::t_phase      r_phase, n_phase;
    logic [7:0]             r_flag, n_flag;
    logic [7:0]             r_type, n_type;
    logic [15:0]            r_rem [LEVELS];
    logic [15:0]            n_rem [LEVELS];
    logic [LEVELS-1:0]      r_skip, n_skip;
    logic [NW-1:0]          r_nest, n_nest;
    logic [7:0]             r_ie_type, n_ie_type;
    logic [15:0]            r_ie_len, n_ie_len;
    logic [15:0]            r_vidx, n_vidx;
    logic [39:0]            r_vshift, n_vshift;
    logic [31:0]            r_teid, n_teid;
    logic                   r_has_teid, n_has_teid;
    logic [7:0]             r_cause, n_cause;
    logic                   r_has_cause, n_has_cause;
    logic [3:0]             r_ebi, n_ebi;
    logic                   r_has_ebi, n_has_ebi;
    logic [31:0]            r_ipv4, n_ipv4;
    logic                   r_has_ip, n_has_ip;
    logic [59:0]            r_imsi, n_imsi;
    logic [3:0]             r_imsi_cnt, n_imsi_cnt;
    logic                   r_imsi_stop, n_imsi_stop;

    logic        res_status;
    logic [7:0]  res_type;
    logic [31:0] res_teid;
    logic        res_has_teid;
    logic [7:0]  res_cause;
    logic        res_has_cause;
    logic [3:0]  res_ebi;
    logic        res_has_ebi;
    logic [31:0] res_ipv4;
    logic        res_has_ip;
    logic [59:0] res_imsi;
    logic [3:0]  res_imsi_cnt;

    logic        r_out_valid;

    assign o_stall   = r_in_valid && r_in_last && r_out_valid && i_stall;
    assign proc_fire = r_in_valid && !o_stall;
    assign o_valid   = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_in_data  <= i_data_byte;
            r_in_first <= i_first_byte;
            r_in_last  <= i_last_byte;
            r_in_tlen  <= i_total_len;
        end
    end

    always_comb begin : p_next
        logic [NW-1:0] lv;
        logic [NW-1:0] lv_up;
        logic [15:0]   rem_lv;
        logic          skip_lv;
        logic [15:0]   idx;
        logic          descend;
        logic          skip_ie;
        logic [3:0]    lo;
        logic [3:0]    hi;
        logic [4:0]    hl;
        logic [15:0]   cur;
        logic [7:0]    b;

        if (r_in_first) begin
            n_bpos      = '0;
            n_phase     = gtpv2_pkg::PH_HDR;
            n_flag      = '0;
            n_type      = '0;
            for (int k = 0; k < LEVELS; k++) begin
                n_rem[k] = '0;
            end
            n_skip      = '0;
            n_nest      = '0;
            n_ie_type   = '0;
            n_ie_len    = '0;
            n_vidx      = '0;
            n_vshift    = '0;
            n_teid      = '0;
            n_has_teid  = 1'b0;
            n_cause     = '0;
            n_has_cause = 1'b0;
            n_ebi       = '0;
            n_has_ebi   = 1'b0;
            n_ipv4      = '0;
            n_has_ip    = 1'b0;
            n_imsi      = '0;
            n_imsi_cnt  = '0;
            n_imsi_stop = 1'b0;
        end else begin
            n_bpos      = r_bpos;
            n_phase     = r_phase;
            n_flag      = r_flag;
            n_type      = r_type;
            for (int k = 0; k < LEVELS; k++) begin
                n_rem[k] = r_rem[k];
            end
            n_skip      = r_skip;
            n_nest      = r_nest;
            n_ie_type   = r_ie_type;
            n_ie_len    = r_ie_len;
            n_vidx      = r_vidx;
            n_vshift    = r_vshift;
            n_teid      = r_teid;
            n_has_teid  = r_has_teid;
            n_cause     = r_cause;
            n_has_cause = r_has_cause;
            n_ebi       = r_ebi;
            n_has_ebi   = r_has_ebi;
            n_ipv4      = r_ipv4;
            n_has_ip    = r_has_ip;
            n_imsi      = r_imsi;
            n_imsi_cnt  = r_imsi_cnt;
            n_imsi_stop = r_imsi_stop;
        end

        b       = r_in_data;
        lv      = n_nest;
        lv_up   = n_nest + 1'b1;
        descend = 1'b0;
        skip_ie = 1'b0;
        idx     = n_vidx;
        lo      = b[3:0];
        hi      = b[7:4];
        hl      = '0;
        cur     = '0;
        rem_lv  = '0;
        skip_lv = 1'b0;
        for (int k = 0; k < LEVELS; k++) begin
            if (NW'(k) == lv) begin
                rem_lv  = n_rem[k];
                skip_lv = n_skip[k];
            end
        end

        if (n_bpos < r_in_tlen) begin
            if (n_phase == gtpv2_pkg::PH_HDR) begin
                if (n_bpos == 16'd0) begin
                    n_flag = b;
                end else if (n_bpos == 16'd1) begin
                    n_type = b;
                end else if (n_bpos >= 16'd4 && n_bpos <= 16'd7) begin
                    n_vshift = {8'h00, n_vshift[23:0], b};
                end
                hl = gtpv2_pkg::hdr_len(n_flag);
                if ({1'b0, n_bpos} + 17'd1 == 17'(hl)) begin
                    if (gtpv2_pkg::header_ok(n_flag, n_type, r_in_tlen)) begin
                        if (n_flag[gtpv2_pkg::T_FLAG_BIT]) begin
                            n_teid     = n_vshift[31:0];
                            n_has_teid = 1'b1;
                        end
                        n_vshift = '0;
                        n_rem[0] = r_in_tlen - 16'(hl);
                        n_nest   = '0;
                        n_vidx   = '0;
                        n_phase  = (n_rem[0] != 16'd0) ? gtpv2_pkg::PH_IEH
                                                        : gtpv2_pkg::PH_DONE;
                    end else begin
                        n_phase = gtpv2_pkg::PH_DONE;
                    end
                end
            end else if (n_phase == gtpv2_pkg::PH_IEH || n_phase == gtpv2_pkg::PH_VAL) begin
                if (n_rem[0] == 16'd0) begin
                    n_phase = gtpv2_pkg::PH_DONE;
                end else begin
                    if (skip_lv) begin
                        n_phase = n_phase;
                    end else if (n_phase == gtpv2_pkg::PH_IEH) begin
                        if (idx == 16'd0) begin
                            if (rem_lv < gtpv2_pkg::IE_HDR_BYTES) begin
                                skip_ie = 1'b1;
                            end else begin
                                n_ie_type = b;
                            end
                        end else if (idx == 16'd1) begin
                            n_ie_len = {b, 8'h00};
                        end else if (idx == 16'd2) begin
                            n_ie_len = n_ie_len | {8'h00, b};
                            if ({1'b0, n_ie_len} + 17'd2 > {1'b0, rem_lv}) begin
                                skip_ie = 1'b1;
                            end
                        end else begin
                            if (n_ie_len != 16'd0) begin
                                if (n_ie_type == gtpv2_pkg::IE_BEARER_CTX &&
                                    {1'b0, lv} < (NW+1)'(NEST_DEPTH)) begin
                                    descend = 1'b1;
                                end else begin
                                    n_phase  = gtpv2_pkg::PH_VAL;
                                    n_vshift = '0;
                                    if (n_ie_type == gtpv2_pkg::IE_IMSI) begin
                                        n_imsi      = '0;
                                        n_imsi_cnt  = '0;
                                        n_imsi_stop = 1'b0;
                                    end
                                end
                            end
                        end
                        for (int k = 0; k < LEVELS; k++) begin
                            if (skip_ie && NW'(k) == lv) begin
                                n_skip[k] = 1'b1;
                            end
                        end
                        n_vidx = (idx >= 16'd3 || skip_ie) ? 16'd0 : idx + 16'd1;
                    end else begin
                        if (idx < gtpv2_pkg::SHIFT_BYTES) begin
                            n_vshift = {n_vshift[31:0], b};
                        end
                        case (n_ie_type)
                            gtpv2_pkg::IE_IMSI: begin
                                if (!n_imsi_stop) begin
                                    if ({1'b0, n_imsi_cnt} + 5'd1 < 5'(IMSI_MAX_DIGITS)) begin
                                        if (lo <= gtpv2_pkg::BCD_MAX &&
                                            n_imsi_cnt < gtpv2_pkg::IMSI_SLOTS) begin
                                            n_imsi = n_imsi | (60'(lo) << {n_imsi_cnt, 2'b00});
                                            n_imsi_cnt = n_imsi_cnt + 4'd1;
                                        end
                                        if (hi <= gtpv2_pkg::BCD_MAX) begin
                                            if (n_imsi_cnt < gtpv2_pkg::IMSI_SLOTS) begin
                                                n_imsi = n_imsi |
                                                         (60'(hi) << {n_imsi_cnt, 2'b00});
                                                n_imsi_cnt = n_imsi_cnt + 4'd1;
                                            end
                                        end else if (hi == gtpv2_pkg::BCD_FILLER) begin
                                            n_imsi_stop = 1'b1;
                                        end
                                    end else begin
                                        n_imsi_stop = 1'b1;
                                    end
                                end
                            end
                            gtpv2_pkg::IE_CAUSE: begin
                                if (idx == 16'd0) begin
                                    n_cause     = b;
                                    n_has_cause = 1'b1;
                                end
                            end
                            gtpv2_pkg::IE_EBI: begin
                                if (idx == 16'd0) begin
                                    n_ebi     = b[3:0];
                                    n_has_ebi = 1'b1;
                                end
                            end
                            gtpv2_pkg::IE_PAA: begin
                                if (idx == gtpv2_pkg::LAST_ADDR_IDX &&
                                    n_vshift[39:32] == gtpv2_pkg::PAA_TYPE_IPV4) begin
                                    n_ipv4   = n_vshift[31:0];
                                    n_has_ip = 1'b1;
                                end
                            end
                            gtpv2_pkg::IE_FTEID: begin
                                if (idx == gtpv2_pkg::LAST_ADDR_IDX) begin
                                    n_teid     = n_vshift[31:0];
                                    n_has_teid = 1'b1;
                                end
                            end
                            default: begin
                                n_vidx = n_vidx;
                            end
                        endcase
                        n_vidx = idx + 16'd1;
                        if (n_vidx >= n_ie_len) begin
                            n_phase = gtpv2_pkg::PH_IEH;
                            n_vidx  = '0;
                        end
                    end

                    for (int k = 0; k < LEVELS; k++) begin
                        if (NW'(k) <= lv && n_rem[k] != 16'd0) begin
                            n_rem[k] = n_rem[k] - 16'd1;
                        end
                    end

                    if (descend) begin
                        for (int k = 0; k < LEVELS; k++) begin
                            if (NW'(k) == lv_up) begin
                                n_rem[k]  = n_ie_len;
                                n_skip[k] = 1'b0;
                            end
                        end
                        n_nest  = lv_up;
                        n_phase = gtpv2_pkg::PH_IEH;
                        n_vidx  = '0;
                    end

                    for (int it = 0; it < NEST_DEPTH; it++) begin
                        cur = '0;
                        for (int k = 0; k < LEVELS; k++) begin
                            if (NW'(k) == n_nest) begin
                                cur = n_rem[k];
                            end
                        end
                        if (n_nest != '0 && cur == 16'd0) begin
                            for (int k = 0; k < LEVELS; k++) begin
                                if (NW'(k) == n_nest) begin
                                    n_skip[k] = 1'b0;
                                end
                            end
                            n_nest  = n_nest - 1'b1;
                            n_phase = gtpv2_pkg::PH_IEH;
                            n_vidx  = '0;
                        end
                    end

                    if (n_rem[0] == 16'd0) begin
                        n_phase = gtpv2_pkg::PH_DONE;
                    end
                end
            end
        end

        if (n_bpos != 16'hffff) begin
            n_bpos = n_bpos + 16'd1;
        end
    end

    always_comb begin : p_result
        res_status    = 1'b1;
        res_type      = '0;
        res_teid      = '0;
        res_has_teid  = 1'b0;
        res_cause     = '0;
        res_has_cause = 1'b0;
        res_ebi       = '0;
        res_has_ebi   = 1'b0;
        res_ipv4      = '0;
        res_has_ip    = 1'b0;
        res_imsi      = '0;
        res_imsi_cnt  = '0;
        if (gtpv2_pkg::header_ok(n_flag, n_type, r_in_tlen)) begin
            res_status    = 1'b0;
            res_type      = n_type;
            res_teid      = n_teid;
            res_has_teid  = n_has_teid;
            res_cause     = n_cause;
            res_has_cause = n_has_cause;
            res_ebi       = n_ebi;
            res_has_ebi   = n_has_ebi;
            res_ipv4      = n_ipv4;
            res_has_ip    = n_has_ip;
            res_imsi      = n_imsi;
            res_imsi_cnt  = n_imsi_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc_fire && r_in_last)) begin
            r_bpos      <= '0;
            r_phase     <= gtpv2_pkg::PH_HDR;
            r_flag      <= '0;
            r_type      <= '0;
            for (int k = 0; k < LEVELS; k++) begin
                r_rem[k] <= '0;
            end
            r_skip      <= '0;
            r_nest      <= '0;
            r_ie_type   <= '0;
            r_ie_len    <= '0;
            r_vidx      <= '0;
            r_vshift    <= '0;
            r_teid      <= '0;
            r_has_teid  <= 1'b0;
            r_cause     <= '0;
            r_has_cause <= 1'b0;
            r_ebi       <= '0;
            r_has_ebi   <= 1'b0;
            r_ipv4      <= '0;
            r_has_ip    <= 1'b0;
            r_imsi      <= '0;
            r_imsi_cnt  <= '0;
            r_imsi_stop <= 1'b0;
        end else if (proc_fire) begin
            r_bpos      <= n_bpos;
            r_phase     <= n_phase;
            r_flag      <= n_flag;
            r_type      <= n_type;
            for (int k = 0; k < LEVELS; k++) begin
                r_rem[k] <= n_rem[k];
            end
            r_skip      <= n_skip;
            r_nest      <= n_nest;
            r_ie_type   <= n_ie_type;
            r_ie_len    <= n_ie_len;
            r_vidx      <= n_vidx;
            r_vshift    <= n_vshift;
            r_teid      <= n_teid;
            r_has_teid  <= n_has_teid;
            r_cause     <= n_cause;
            r_has_cause <= n_has_cause;
            r_ebi       <= n_ebi;
            r_has_ebi   <= n_has_ebi;
            r_ipv4      <= n_ipv4;
            r_has_ip    <= n_has_ip;
            r_imsi      <= n_imsi;
            r_imsi_cnt  <= n_imsi_cnt;
            r_imsi_stop <= n_imsi_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (proc_fire && r_in_last) begin
            o_status        <= res_status;
            o_msg_type      <= res_type;
            o_teid          <= res_teid;
            o_has_teid      <= res_has_teid;
            o_cause_code    <= res_cause;
            o_has_cause     <= res_has_cause;
            o_bearer_id     <= res_ebi;
            o_has_bearer_id <= res_has_ebi;
            o_ue_ipv4       <= res_ipv4;
            o_has_ue_ip     <= res_has_ip;
            o_imsi_bcd      <= res_imsi;
            o_imsi_count    <= res_imsi_cnt;
        end
    end

endmodule

>>> src/gtpv2_chk.sv
// Port checker for the GTPv2-C field extractor, bound to its top level.
// Depends only on the top level's ports; uses no package items.
module gtpv2_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_first_byte,
    input logic        i_last_byte,
    input logic [15:0] i_total_len,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_status,
    input logic [7:0]  o_msg_type,
    input logic [31:0] o_teid,
    input logic        o_has_teid,
    input logic [7:0]  o_cause_code,
    input logic        o_has_cause,
    input logic [3:0]  o_bearer_id,
    input logic        o_has_bearer_id,
    input logic [31:0] o_ue_ipv4,
    input logic        o_has_ue_ip,
    input logic [59:0] o_imsi_bcd,
    input logic [3:0]  o_imsi_count
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("A result is shown right after reset.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_teid) &&
                               $stable(o_imsi_bcd) && $stable(o_msg_type))
        else $error("A stalled result changed or vanished.");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_msg_type == 8'd0 && !o_has_teid && !o_has_cause &&
                               !o_has_bearer_id && !o_has_ue_ip && o_imsi_count == 4'd0)
        else $error("A rejected packet carries captured fields.");

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_has_teid || o_teid == 32'd0) && (o_has_ue_ip || o_ue_ipv4 == 32'd0) &&
                    (o_has_cause || o_cause_code == 8'd0) &&
                    (o_has_bearer_id || o_bearer_id == 4'd0))
        else $error("A field without its flag is not zero.");

    a_imsi_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_imsi_count == 4'd0 |-> o_imsi_bcd == 60'd0)
        else $error("IMSI digits are shown with a zero digit count.");

endmodule

bind gtpv2c_field_extract gtpv2_chk u_gtpv2_chk (.*);
